// ===== design/dtr_pkg.sv =====
// Shared types and constants for the DAG transitive reduction block.
package dtr_pkg;

	// width of a stage index field on the ports
	localparam int FIELD_W = 3;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_REACH,
		ST_READ,
		ST_CHECK,
		ST_FLUSH
	} state_t;

endpackage

// ===== design/dtr_if.sv =====
// Valid/ready channel interfaces for incoming edges and kept edges.
interface dtr_edge_if import dtr_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [FIELD_W-1:0] producer;
	logic [FIELD_W-1:0] consumer;
	logic               waits_all;
	logic               last_edge;

	modport source(output valid, producer, consumer, waits_all, last_edge, input ready);
	modport sink(input valid, producer, consumer, waits_all, last_edge, output ready);
endinterface

interface dtr_kept_if import dtr_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [FIELD_W-1:0] kept_producer;
	logic [FIELD_W-1:0] kept_consumer;
	logic               final_result;

	modport source(output valid, kept_producer, kept_consumer, final_result, input ready);
	modport sink(input valid, kept_producer, kept_consumer, final_result, output ready);
endinterface

// ===== design/dag_transitive_reduction.sv =====
// Edges load at one word per cycle while the block is collecting a batch. The word marked
// last starts the reduction, during which the edge input is not ready: the reachability
// rows are built first, one consumer stage per cycle, then each stored edge is read from
// the edge RAM (registered read data) and given the redundancy check, and a flush step
// releases the final kept edge. A kept edge's check and the flush wait while the kept
// output stalls. An empty batch returns to loading once the reachability rows are built.
// Kept edges leave through an output register, one edge behind the check, so the final
// word can carry its end-of-batch mark.
module dag_transitive_reduction import dtr_pkg::*; #(
	parameter int STAGES     = 8,
	parameter int EDGE_SLOTS = 32
) (
	input logic       clk,
	input logic       arst_n,
	dtr_edge_if.sink  edges,
	dtr_kept_if.source kept
);

	localparam int STG_W = $clog2(STAGES);
	localparam int AW    = $clog2(EDGE_SLOTS);
	localparam int CW    = $clog2(EDGE_SLOTS + 1);
	localparam int RW    = 2 * STG_W;
	localparam logic [FIELD_W:0] STAGES_LIM = (FIELD_W + 1)'(STAGES);
	localparam logic [STG_W-1:0] STG_LAST   = STG_W'(STAGES - 1);

	state_t state_q, state_d;

	logic [STAGES-1:0] seen_q  [STAGES];
	logic [STAGES-1:0] wi_q    [STAGES];
	logic [STAGES-1:0] reach_q [STAGES];

	logic [CW-1:0]    total_q;
	logic [CW-1:0]    idx_q;
	logic [STG_W-1:0] stg_q;

	logic             pend_valid_q;
	logic [STG_W-1:0] pend_src_q;
	logic [STG_W-1:0] pend_dst_q;

	logic               out_valid_q;
	logic [FIELD_W-1:0] out_prod_q;
	logic [FIELD_W-1:0] out_cons_q;
	logic               out_final_q;

	// load side
	logic             in_acc, legal, dup, room, store, mark_whole;
	logic [STG_W-1:0] ld_p, ld_c;

	// reduction side
	logic [RW-1:0]     rdata;
	logic [STG_W-1:0]  chk_src, chk_dst;
	logic [STG_W-1:0]  wi_addr;
	logic [STAGES-1:0] wi_row;
	logic [STAGES-1:0] reach_row;
	logic              implied;
	logic              out_free, idx_last;

	// FSM controls
	logic ram_re, adv, take, out_load, out_final, clear, reach_we;

	assign in_acc = edges.valid && edges.ready;
	assign ld_p   = edges.producer[STG_W-1:0];
	assign ld_c   = edges.consumer[STG_W-1:0];
	assign legal  = ({1'b0, edges.producer} < STAGES_LIM)
		&& ({1'b0, edges.consumer} < STAGES_LIM)
		&& (edges.producer < edges.consumer);
	assign dup        = legal && seen_q[ld_c][ld_p];
	assign room       = total_q < CW'(EDGE_SLOTS);
	assign store      = in_acc && legal && !dup && room;
	assign mark_whole = in_acc && legal && (dup || room) && edges.waits_all;

	assign edges.ready = (state_q == ST_LOAD);

	dtr_ram #(
		.WIDTH(RW),
		.DEPTH(EDGE_SLOTS)
	) u_edge_ram (
		.clk  (clk),
		.we   (store),
		.waddr(total_q[AW-1:0]),
		.wdata({ld_p, ld_c}),
		.re   (ram_re),
		.raddr(idx_q[AW-1:0]),
		.rdata(rdata)
	);

	assign chk_src = rdata[RW-1:STG_W];
	assign chk_dst = rdata[STG_W-1:0];

	// one read port on the whole-wait matrix, shared by reach build and check
	assign wi_addr = (state_q == ST_REACH) ? stg_q : chk_dst;
	assign wi_row  = wi_q[wi_addr];

	always_comb begin
		reach_row = '0;
		for (int p = 0; p < STAGES; p++) begin
			if (STG_W'(p) < stg_q && wi_row[p]) begin
				reach_row = reach_row | (STAGES'(1) << p) | reach_q[p];
			end
		end
	end

	always_comb begin
		implied = 1'b0;
		for (int o = 0; o < STAGES; o++) begin
			if (STG_W'(o) != chk_src && wi_row[o] && reach_q[o][chk_src]) begin
				implied = 1'b1;
			end
		end
	end

	assign out_free = !out_valid_q || kept.ready;
	assign idx_last = (idx_q + CW'(1)) == total_q;

	always_comb begin
		state_d   = state_q;
		ram_re    = 1'b0;
		adv       = 1'b0;
		take      = 1'b0;
		out_load  = 1'b0;
		out_final = 1'b0;
		clear     = 1'b0;
		reach_we  = 1'b0;
		case (state_q)
			ST_LOAD: begin
				if (in_acc && edges.last_edge) begin
					state_d = ST_REACH;
				end
			end
			ST_REACH: begin
				reach_we = 1'b1;
				if (stg_q == STG_LAST) begin
					if (total_q == '0) begin
						clear   = 1'b1;
						state_d = ST_LOAD;
					end else begin
						state_d = ST_READ;
					end
				end
			end
			ST_READ: begin
				ram_re  = 1'b1;
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (implied) begin
					adv     = 1'b1;
					state_d = idx_last ? ST_FLUSH : ST_READ;
				end else if (!pend_valid_q || out_free) begin
					// previous kept edge moves out, this one waits for a successor
					take     = 1'b1;
					out_load = pend_valid_q;
					adv      = 1'b1;
					state_d  = idx_last ? ST_FLUSH : ST_READ;
				end
			end
			ST_FLUSH: begin
				if (!pend_valid_q) begin
					clear   = 1'b1;
					state_d = ST_LOAD;
				end else if (out_free) begin
					out_load  = 1'b1;
					out_final = 1'b1;
					clear     = 1'b1;
					state_d   = ST_LOAD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			idx_q   <= '0;
			stg_q   <= '0;
			for (int i = 0; i < STAGES; i++) begin
				seen_q[i]  <= '0;
				wi_q[i]    <= '0;
				reach_q[i] <= '0;
			end
		end else begin
			if (clear) begin
				total_q <= '0;
				idx_q   <= '0;
				for (int i = 0; i < STAGES; i++) begin
					seen_q[i]  <= '0;
					wi_q[i]    <= '0;
					reach_q[i] <= '0;
				end
			end else begin
				if (store) begin
					total_q          <= total_q + CW'(1);
					seen_q[ld_c][ld_p] <= 1'b1;
				end
				if (mark_whole) begin
					wi_q[ld_c][ld_p] <= 1'b1;
				end
				if (reach_we) begin
					reach_q[stg_q] <= reach_row;
				end
				if (adv) begin
					idx_q <= idx_q + CW'(1);
				end
			end
			if (reach_we) begin
				stg_q <= (stg_q == STG_LAST) ? '0 : stg_q + STG_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (take) begin
				pend_valid_q <= 1'b1;
			end else if (out_load) begin
				pend_valid_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (kept.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			pend_src_q <= chk_src;
			pend_dst_q <= chk_dst;
		end
		if (out_load) begin
			out_prod_q  <= FIELD_W'(pend_src_q);
			out_cons_q  <= FIELD_W'(pend_dst_q);
			out_final_q <= out_final;
		end
	end

	assign kept.valid         = out_valid_q;
	assign kept.kept_producer = out_prod_q;
	assign kept.kept_consumer = out_cons_q;
	assign kept.final_result  = out_final_q;

endmodule

// ===== design/dtr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dtr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== design/dtr_checker.sv =====
// Port-level checks for the DAG transitive reduction block, bound to the top level.
module dtr_checker import dtr_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               in_last,
	input logic               out_valid,
	input logic               out_ready,
	input logic [FIELD_W-1:0] out_producer,
	input logic [FIELD_W-1:0] out_consumer,
	input logic               out_final
);

	// a stalled kept word stays up
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("kept word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable({out_producer, out_consumer, out_final}))
		else $error("kept word changed while stalled");

	// the last word of a batch starts the reduction, so input closes next cycle
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_last |=> !in_ready)
		else $error("input still open after last word");

	// kept words come only from the reduction pass
	a_out_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("kept word produced while loading");

	a_out_forward: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_producer < out_consumer)
		else $error("kept word is not a forward edge");

endmodule

bind dag_transitive_reduction dtr_checker u_dtr_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (edges.valid),
	.in_ready    (edges.ready),
	.in_last     (edges.last_edge),
	.out_valid   (kept.valid),
	.out_ready   (kept.ready),
	.out_producer(kept.kept_producer),
	.out_consumer(kept.kept_consumer),
	.out_final   (kept.final_result)
);
